FILE: hw/rtl/gmb_pkg.sv
// Package for the grid maze backtracker: grid sizes, codes, the interface
// structs between controller and datapath, and the mod-3 helper.
// No dependencies.
`default_nettype none

package gmb_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;
    localparam int CELL_W      = COL_W + ROW_W;
    localparam int CNT_W       = $clog2(CELL_COUNT + 1);
    localparam int DIM_W       = 7;
    localparam int AREA_W      = 2 * DIM_W;
    localparam int RND_W       = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        ACT_CARVE   = 2'd0,
        ACT_BACK    = 2'd1,
        ACT_DONE    = 2'd2,
        ACT_RESTART = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        DIR_LEFT  = 2'd0,
        DIR_UP    = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_DOWN  = 2'd3
    } t_dir;

    typedef enum logic [1:0] {
        RD_MID = 2'd0,
        RD_UP  = 2'd1,
        RD_DN  = 2'd2
    } t_rd_sel;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RD_UP,
        ST_RD_DN,
        ST_DECIDE,
        ST_POP,
        ST_CLEAR,
        ST_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    take;      // request accepted: latch random digits
        logic    restart;   // apply restart and load its result
        logic    finish;    // load finished result
        logic    rd_en;     // read one row of the visited map
        t_rd_sel rd_sel;
        logic    cap_mid;
        logic    cap_up;
        logic    decide;    // carve, or start a pop
        logic    pop_load;  // take popped cell
        logic    clr_step;  // clear one row of the visited map
        logic    emit;      // move pending result to the output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic finished;
        logic has_nbr;
        logic stack_empty;
        logic clr_last;
        logic out_free;
    } t_dp_stat;

    // value mod 3 by summing base-4 digits (4 = 1 mod 3)
    function automatic logic [1:0] mod3_word(input logic [RND_W-1:0] v);
        logic [4:0] s;
        logic [2:0] t;
        logic [2:0] r;
        s = '0;
        for (int k = 0; k < RND_W / 2; k++) begin
            s = s + 5'(v[2*k +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            r = t - 3'd6;
        end else if (t >= 3'd3) begin
            r = t - 3'd3;
        end else begin
            r = t;
        end
        return r[1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/grid_maze_backtracker.sv
// Top level of the grid maze backtracker (randomised depth-first carver).
// Depends on gmb_pkg, gmb_ctrl and gmb_datapath.
//
//  channel  handshake                  payload
//  -------  -------------------------  ----------------------------------------
//  in       i_in_valid / o_in_ready    i_command, i_random_word
//  out      o_out_valid / i_out_ready  o_action, o_from_x/y, o_direction, o_to_x/y
//  cfg      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A carve step runs from the request state through three serial row reads of
// the visited map (the first in the request state), a decide state and an emit
// state that loads the output register; a backtrack with a non-empty stack adds a pop state.
// A finished step goes from the request state straight to emit. Reset and each restart clear
// the map one row per cycle, all 64 rows; no request is taken meanwhile, configuration writes always are.
// A waiting result holds the next item only in the emit state.
`default_nettype none

module grid_maze_backtracker import gmb_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_command,
    input  wire logic [RND_W-1:0]     i_random_word,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [1:0]                o_action,
    output logic [COL_W-1:0]          o_from_x,
    output logic [ROW_W-1:0]          o_from_y,
    output logic [1:0]                o_direction,
    output logic [COL_W-1:0]          o_to_x,
    output logic [ROW_W-1:0]          o_to_y,
    // configuration write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIM_W-1:0]     i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // grid registers are plain flops: accept a write in any cycle
    assign o_cfg_ready = 1'b1;

    gmb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    gmb_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_random_word (i_random_word),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_action      (o_action),
        .o_from_x      (o_from_x),
        .o_from_y      (o_from_y),
        .o_direction   (o_direction),
        .o_to_x        (o_to_x),
        .o_to_y        (o_to_y)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/gmb_ctrl.sv
// Sequencing state machine of the maze backtracker.
// Depends on gmb_pkg; drives gmb_datapath through t_dp_cmd.
`default_nettype none

module gmb_ctrl import gmb_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_command,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.rd_sel = RD_MID;
        o_in_ready = 1'b0;
        case (r_state)
            ST_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (!i_command) begin
                        o_cmd.restart = 1'b1;
                        n_state = ST_CLEAR;
                    end else if (i_stat.finished) begin
                        o_cmd.finish = 1'b1;
                        n_state = ST_EMIT;
                    end else begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RD_MID;
                        n_state = ST_RD_UP;
                    end
                end
            end
            ST_RD_UP: begin
                o_cmd.cap_mid = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RD_UP;
                n_state = ST_RD_DN;
            end
            ST_RD_DN: begin
                o_cmd.cap_up = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_DN;
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_stat.has_nbr || i_stat.stack_empty) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_POP;
                end
            end
            ST_POP: begin
                o_cmd.pop_load = 1'b1;
                n_state = ST_EMIT;
            end
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gmb_datapath.sv
// Datapath of the maze backtracker: visited map (row memory), path stack
// memory, current cell, counters, grid registers and the result register.
// Depends on gmb_pkg; controlled by gmb_ctrl.
`default_nettype none

module gmb_datapath import gmb_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    input  wire logic [RND_W-1:0]     i_random_word,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIM_W-1:0]     i_cfg_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [1:0]                o_action,
    output logic [COL_W-1:0]          o_from_x,
    output logic [ROW_W-1:0]          o_from_y,
    output logic [1:0]                o_direction,
    output logic [COL_W-1:0]          o_to_x,
    output logic [ROW_W-1:0]          o_to_y
);

    // memories
    logic [MAX_COLUMNS-1:0] vis_mem [MAX_ROWS];
    logic [CELL_W-1:0]      stk_mem [CELL_COUNT];

    // control state
    logic [DIM_W-1:0] r_cfg_w;
    logic [DIM_W-1:0] r_cfg_h;
    logic [COL_W-1:0] r_cur_x;
    logic [ROW_W-1:0] r_cur_y;
    logic [CNT_W-1:0] r_depth;
    logic [CNT_W-1:0] r_count;
    logic [ROW_W-1:0] r_clr_idx;
    logic             r_out_valid;

    // payload
    logic [MAX_COLUMNS-1:0] r_vis_rd;
    logic [MAX_COLUMNS-1:0] r_row_mid;
    logic [MAX_COLUMNS-1:0] r_row_up;
    logic [CELL_W-1:0]      r_stk_rd;
    logic [1:0]             r_rnd_lo;
    logic [1:0]             r_rnd_mod3;
    t_action                r_res_act;
    logic [COL_W-1:0]       r_res_fx;
    logic [ROW_W-1:0]       r_res_fy;
    t_dir                   r_res_dir;
    logic [COL_W-1:0]       r_res_tx;
    logic [ROW_W-1:0]       r_res_ty;
    t_action                r_out_act;
    logic [COL_W-1:0]       r_out_fx;
    logic [ROW_W-1:0]       r_out_fy;
    t_dir                   r_out_dir;
    logic [COL_W-1:0]       r_out_tx;
    logic [ROW_W-1:0]       r_out_ty;

    logic [DIM_W-1:0]       dim_w;
    logic [DIM_W-1:0]       dim_h;
    logic [AREA_W-1:0]      area;
    logic [COL_W-1:0]       x_m1;
    logic [COL_W-1:0]       x_p1;
    logic [3:0]             nbr_ok;
    logic [2:0]             nbr_cnt;
    logic [1:0]             pick;
    logic [1:0]             seen;
    logic                   found;
    t_dir                   dir;
    logic [COL_W-1:0]       new_x;
    logic [ROW_W-1:0]       new_y;
    logic [MAX_COLUMNS-1:0] new_row;
    logic [ROW_W-1:0]       rd_addr;
    logic                   vis_we;
    logic [ROW_W-1:0]       vis_waddr;
    logic [MAX_COLUMNS-1:0] vis_wdata;
    logic [CNT_W-1:0]       depth_m1;
    logic                   carve;

    // clamp the grid size: zero acts as one, oversize as the maximum
    always_comb begin
        if (r_cfg_w == '0) begin
            dim_w = DIM_W'(1);
        end else if (r_cfg_w > DIM_W'(MAX_COLUMNS)) begin
            dim_w = DIM_W'(MAX_COLUMNS);
        end else begin
            dim_w = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            dim_h = DIM_W'(1);
        end else if (r_cfg_h > DIM_W'(MAX_ROWS)) begin
            dim_h = DIM_W'(MAX_ROWS);
        end else begin
            dim_h = r_cfg_h;
        end
        area = AREA_W'(dim_w) * AREA_W'(dim_h);
    end

    // neighbour test; the down row is still in the read register
    always_comb begin
        x_m1 = r_cur_x - COL_W'(1);
        x_p1 = r_cur_x + COL_W'(1);
        nbr_ok[0] = (r_cur_x != '0) && !r_row_mid[x_m1];
        nbr_ok[1] = (r_cur_y != '0) && !r_row_up[r_cur_x];
        nbr_ok[2] = ((DIM_W'(r_cur_x) + DIM_W'(1)) < dim_w) && !r_row_mid[x_p1];
        nbr_ok[3] = ((DIM_W'(r_cur_y) + DIM_W'(1)) < dim_h) && !r_vis_rd[r_cur_x];
        nbr_cnt = 3'(nbr_ok[0]) + 3'(nbr_ok[1]) + 3'(nbr_ok[2]) + 3'(nbr_ok[3]);
        case (nbr_cnt)
            3'd2:    pick = {1'b0, r_rnd_lo[0]};
            3'd3:    pick = r_rnd_mod3;
            3'd4:    pick = r_rnd_lo;
            default: pick = 2'd0;
        endcase
        seen  = 2'd0;
        found = 1'b0;
        dir   = DIR_LEFT;
        for (int k = 0; k < 4; k++) begin
            if (nbr_ok[k] && !found) begin
                if (seen == pick) begin
                    dir   = t_dir'(k);
                    found = 1'b1;
                end
                seen = seen + 2'd1;
            end
        end
        case (dir)
            DIR_LEFT: begin
                new_x = x_m1;
                new_y = r_cur_y;
                new_row = r_row_mid;
            end
            DIR_UP: begin
                new_x = r_cur_x;
                new_y = r_cur_y - ROW_W'(1);
                new_row = r_row_up;
            end
            DIR_RIGHT: begin
                new_x = x_p1;
                new_y = r_cur_y;
                new_row = r_row_mid;
            end
            default: begin
                new_x = r_cur_x;
                new_y = r_cur_y + ROW_W'(1);
                new_row = r_vis_rd;
            end
        endcase
    end

    assign carve    = i_cmd.decide && (nbr_cnt != 3'd0);
    assign depth_m1 = r_depth - CNT_W'(1);

    // visited map: one write port shared by the clearing pass and carving
    always_comb begin
        case (i_cmd.rd_sel)
            RD_UP:   rd_addr = r_cur_y - ROW_W'(1);
            RD_DN:   rd_addr = r_cur_y + ROW_W'(1);
            default: rd_addr = r_cur_y;
        endcase
        vis_we    = 1'b0;
        vis_waddr = r_clr_idx;
        vis_wdata = '0;
        if (i_cmd.clr_step) begin
            vis_we    = 1'b1;
            vis_wdata = (r_clr_idx == '0) ? MAX_COLUMNS'(1) : '0;
        end else if (carve) begin
            vis_we    = 1'b1;
            vis_waddr = new_y;
            vis_wdata = new_row | (MAX_COLUMNS'(1) << new_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        if (i_cmd.rd_en) begin
            r_vis_rd <= vis_mem[rd_addr];
        end
    end

    // path stack: push on carve, read the top in the decide state
    always_ff @(posedge i_clk) begin
        if (carve && (r_depth < CNT_W'(CELL_COUNT))) begin
            stk_mem[r_depth[CELL_W-1:0]] <= {r_cur_y, r_cur_x};
        end
        if (i_cmd.decide) begin
            r_stk_rd <= stk_mem[depth_m1[CELL_W-1:0]];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= DIM_W'(MAX_COLUMNS);
            r_cfg_h     <= DIM_W'(MAX_ROWS);
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_depth     <= '0;
            r_count     <= CNT_W'(1);
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GRID_WIDTH:  r_cfg_w <= i_cfg_data;
                    CFG_GRID_HEIGHT: r_cfg_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.restart) begin
                r_cur_x   <= '0;
                r_cur_y   <= '0;
                r_depth   <= '0;
                r_count   <= CNT_W'(1);
                r_clr_idx <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr_idx <= r_clr_idx + ROW_W'(1);
            end
            if (carve) begin
                r_cur_x <= new_x;
                r_cur_y <= new_y;
                r_count <= r_count + CNT_W'(1);
                if (r_depth < CNT_W'(CELL_COUNT)) begin
                    r_depth <= r_depth + CNT_W'(1);
                end
            end else if (i_cmd.decide && (r_depth != '0)) begin
                r_depth <= depth_m1;
            end
            if (i_cmd.pop_load) begin
                r_cur_x <= r_stk_rd[COL_W-1:0];
                r_cur_y <= r_stk_rd[CELL_W-1:COL_W];
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_rnd_lo   <= i_random_word[1:0];
            r_rnd_mod3 <= mod3_word(i_random_word);
        end
        if (i_cmd.cap_mid) begin
            r_row_mid <= r_vis_rd;
        end
        if (i_cmd.cap_up) begin
            r_row_up <= r_vis_rd;
        end
        if (i_cmd.restart) begin
            r_res_act <= ACT_RESTART;
            r_res_fx  <= r_cur_x;
            r_res_fy  <= r_cur_y;
            r_res_dir <= DIR_LEFT;
            r_res_tx  <= '0;
            r_res_ty  <= '0;
        end else if (i_cmd.finish) begin
            r_res_act <= ACT_DONE;
            r_res_fx  <= r_cur_x;
            r_res_fy  <= r_cur_y;
            r_res_dir <= DIR_LEFT;
            r_res_tx  <= r_cur_x;
            r_res_ty  <= r_cur_y;
        end else if (i_cmd.decide) begin
            r_res_fx <= r_cur_x;
            r_res_fy <= r_cur_y;
            if (carve) begin
                r_res_act <= ACT_CARVE;
                r_res_dir <= dir;
                r_res_tx  <= new_x;
                r_res_ty  <= new_y;
            end else begin
                r_res_act <= ACT_BACK;
                r_res_dir <= DIR_LEFT;
                r_res_tx  <= r_cur_x;
                r_res_ty  <= r_cur_y;
            end
        end else if (i_cmd.pop_load) begin
            r_res_tx <= r_stk_rd[COL_W-1:0];
            r_res_ty <= r_stk_rd[CELL_W-1:COL_W];
        end
        if (i_cmd.emit) begin
            r_out_act <= r_res_act;
            r_out_fx  <= r_res_fx;
            r_out_fy  <= r_res_fy;
            r_out_dir <= r_res_dir;
            r_out_tx  <= r_res_tx;
            r_out_ty  <= r_res_ty;
        end
    end

    assign o_stat.finished    = AREA_W'(r_count) >= area;
    assign o_stat.has_nbr     = nbr_cnt != 3'd0;
    assign o_stat.stack_empty = r_depth == '0;
    assign o_stat.clr_last    = r_clr_idx == ROW_W'(MAX_ROWS - 1);
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_action    = r_out_act;
    assign o_from_x    = r_out_fx;
    assign o_from_y    = r_out_fy;
    assign o_direction = r_out_dir;
    assign o_to_x      = r_out_tx;
    assign o_to_y      = r_out_ty;

endmodule

`default_nettype wire

FILE: sim/tb_grid_maze_backtracker.sv
// Self-checking testbench for grid_maze_backtracker: randomised steps and restarts
// on small and clamped grids, checked against a behavioural carver model.
// Depends on gmb_pkg and the grid_maze_backtracker RTL.
`default_nettype none

module tb_grid_maze_backtracker;
    import gmb_pkg::*;

    // command codes of a request
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_STEP    = 1'b1;

    // idle cycles without any handshake before the run is abandoned
    localparam int IDLE_LIMIT    = 5000;
    localparam int ITEM_TARGET   = 550;

    typedef struct {
        logic             cmd;
        logic [RND_W-1:0] word;
    } t_maze_req;

    typedef struct {
        t_action          act;
        logic [COL_W-1:0] from_x;
        logic [ROW_W-1:0] from_y;
        t_dir             dir;
        logic [COL_W-1:0] to_x;
        logic [ROW_W-1:0] to_y;
    } t_move;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_command = CMD_STEP;
    logic [RND_W-1:0]     i_random_word = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [1:0]           o_action;
    logic [COL_W-1:0]     o_from_x;
    logic [ROW_W-1:0]     o_from_y;
    logic [1:0]           o_direction;
    logic [COL_W-1:0]     o_to_x;
    logic [ROW_W-1:0]     o_to_y;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_GRID_WIDTH;
    logic [DIM_W-1:0]     i_cfg_data = '0;

    grid_maze_backtracker u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_random_word (i_random_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_action      (o_action),
        .o_from_x      (o_from_x),
        .o_from_y      (o_from_y),
        .o_direction   (o_direction),
        .o_to_x        (o_to_x),
        .o_to_y        (o_to_y),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Carver model: its own visited map, path stack and register copies
    // ------------------------------------------------------------------
    bit               seen_cell [CELL_COUNT];
    int               trail [$];
    int               cur_x;
    int               cur_y;
    int               seen_total;
    logic [DIM_W-1:0] grid_w = 7'd64;
    logic [DIM_W-1:0] grid_h = 7'd64;

    t_maze_req        req_queue [$];
    t_move            expected_moves [$];
    int               issued;
    int               mismatch_count;

    function automatic int cell_at(input int x, input int y);
        return y * MAX_COLUMNS + x;
    endfunction

    // clear the map, empty the stack and stand on the origin, which counts as visited
    function automatic void restart_walk();
        foreach (seen_cell[k]) seen_cell[k] = 1'b0;
        trail.delete();
        cur_x = 0;
        cur_y = 0;
        seen_cell[0] = 1'b1;
        seen_total = 1;
    endfunction

    function automatic t_move predict_step(input logic cmd, input logic [RND_W-1:0] word);
        int    w;
        int    h;
        int    n;
        int    pick;
        int    spot;
        int    nx [4];
        int    ny [4];
        t_dir  nd [4];
        t_move r;
        // out-of-range sizes clamp to 1 and to the maximum
        w = (grid_w == 0) ? 1 : ((grid_w > MAX_COLUMNS) ? MAX_COLUMNS : int'(grid_w));
        h = (grid_h == 0) ? 1 : ((grid_h > MAX_ROWS) ? MAX_ROWS : int'(grid_h));
        r.from_x = COL_W'(cur_x);
        r.from_y = ROW_W'(cur_y);
        r.dir    = DIR_LEFT;
        if (cmd == CMD_RESTART) begin
            restart_walk();
            r.act  = ACT_RESTART;
            r.to_x = '0;
            r.to_y = '0;
            return r;
        end
        // finished test uses the cell count of the present grid, whatever was carved before
        if (seen_total >= w * h) begin
            r.act  = ACT_DONE;
            r.to_x = COL_W'(cur_x);
            r.to_y = ROW_W'(cur_y);
            return r;
        end
        // gather unvisited neighbours: left, up, right, down; only right and down see the bounds
        n = 0;
        if (cur_x > 0 && !seen_cell[cell_at(cur_x - 1, cur_y)]) begin
            nx[n] = cur_x - 1; ny[n] = cur_y; nd[n] = DIR_LEFT; n++;
        end
        if (cur_y > 0 && !seen_cell[cell_at(cur_x, cur_y - 1)]) begin
            nx[n] = cur_x; ny[n] = cur_y - 1; nd[n] = DIR_UP; n++;
        end
        if (cur_x + 1 < w && !seen_cell[cell_at(cur_x + 1, cur_y)]) begin
            nx[n] = cur_x + 1; ny[n] = cur_y; nd[n] = DIR_RIGHT; n++;
        end
        if (cur_y + 1 < h && !seen_cell[cell_at(cur_x, cur_y + 1)]) begin
            nx[n] = cur_x; ny[n] = cur_y + 1; nd[n] = DIR_DOWN; n++;
        end
        if (n > 0) begin
            pick = int'(word) % n;
            trail = {trail, cell_at(cur_x, cur_y)};
            cur_x = nx[pick];
            cur_y = ny[pick];
            seen_cell[cell_at(cur_x, cur_y)] = 1'b1;
            seen_total++;
            r.act = ACT_CARVE;
            r.dir = nd[pick];
        end else begin
            // dead end: drop back one cell; an empty stack leaves the cell in place
            if (trail.size() > 0) begin
                spot  = trail.pop_back();
                cur_x = spot % MAX_COLUMNS;
                cur_y = spot / MAX_COLUMNS;
            end
            r.act = ACT_BACK;
        end
        r.to_x = COL_W'(cur_x);
        r.to_y = ROW_W'(cur_y);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin : drive_requests
        logic      fire;
        t_maze_req item;
        t_move     nxt;
        fire = i_in_valid && o_in_ready;
        // predict on acceptance so that config writes and requests stay in order
        if (fire) begin
            nxt = predict_step(i_command, i_random_word);
            expected_moves = {expected_moves, nxt};
        end
        if (i_rst_n && (fire || !i_in_valid)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (req_queue.size() > 0) begin
                item = req_queue.pop_front();
                i_command     <= item.cmd;
                i_random_word <= item.word;
                i_in_valid    <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver stall pattern
    // ------------------------------------------------------------------
    int ready_mode = 0;
    int mode_left  = 0;
    int ready_tick = 0;

    task automatic check_field(input string name, input logic [5:0] want, input logic [5:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : collect_results
        t_move want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_moves.size() == 0) begin
                    $error("result with no request outstanding: action %0d", o_action);
                    mismatch_count++;
                end else begin
                    want = expected_moves.pop_front();
                    check_field("action", 6'(want.act), 6'(o_action));
                    check_field("from_x", 6'(want.from_x), 6'(o_from_x));
                    check_field("from_y", 6'(want.from_y), 6'(o_from_y));
                    check_field("direction", 6'(want.dir), 6'(o_direction));
                    check_field("to_x", 6'(want.to_x), 6'(o_to_x));
                    check_field("to_y", 6'(want.to_y), 6'(o_to_y));
                end
            end
            // switch between always ready, coin-flip stalls and one-in-four ready
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            ready_tick++;
            case (ready_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                default: i_out_ready <= (ready_tick % 4 == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: abandon the run after a long stretch with no handshake
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void queue_req(input logic cmd, input logic [RND_W-1:0] word);
        t_maze_req item;
        item.cmd  = cmd;
        item.word = word;
        req_queue = {req_queue, item};
        issued++;
    endfunction

    // hold until every request is sent and every result has come back
    task automatic wait_idle();
        while (req_queue.size() != 0 || i_in_valid || expected_moves.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // write width then height, keeping valid high across both requests
    task automatic write_grid_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_GRID_WIDTH;
        i_cfg_data  <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        grid_w = w;
        i_cfg_index <= CFG_GRID_HEIGHT;
        i_cfg_data  <= h;
        do @(posedge i_clk); while (!o_cfg_ready);
        grid_h = h;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [DIM_W-1:0] dim_edges [4];
        logic [DIM_W-1:0] cw;
        logic [DIM_W-1:0] ch;
        int               wd;
        int               hd;
        int               steps;
        dim_edges = '{7'd0, 7'd1, 7'd64, 7'd127};
        issued = 0;
        mismatch_count = 0;
        restart_walk();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: first steps on the full reset-size grid, then a restart away from the origin
        queue_req(CMD_STEP, 16'h0000);
        queue_req(CMD_STEP, 16'hFFFF);
        queue_req(CMD_RESTART, 16'hFFFF);
        wait_idle();

        // 2x2: carve, dead ends, backtracks and the finished report
        write_grid_dims(7'd2, 7'd2);
        for (int k = 0; k < 8; k++) begin
            queue_req(CMD_STEP, (k % 2 == 0) ? 16'h0000 : 16'hFFFF);
        end
        wait_idle();

        // resize mid-maze without restart: zero width acts as one, height above maximum clamps
        write_grid_dims(7'd0, 7'd127);
        queue_req(CMD_STEP, 16'h0001);
        queue_req(CMD_STEP, 16'h8000);
        queue_req(CMD_STEP, 16'h7FFF);
        wait_idle();

        write_grid_dims(7'd127, 7'd0);
        queue_req(CMD_RESTART, 16'h5555);
        queue_req(CMD_STEP, 16'hAAAA);
        queue_req(CMD_STEP, 16'h0003);
        queue_req(CMD_STEP, 16'hFFFE);
        wait_idle();

        // single cell: finished straight after restart
        write_grid_dims(7'd1, 7'd1);
        queue_req(CMD_RESTART, 16'h0000);
        queue_req(CMD_STEP, 16'h1234);
        queue_req(CMD_STEP, 16'hFFFF);
        wait_idle();

        // random phases: mostly whole walks over small grids, random content
        while (issued < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0: begin
                    cw = DIM_W'($urandom_range(0, 127));
                    ch = DIM_W'($urandom_range(0, 127));
                end
                1: begin
                    cw = dim_edges[$urandom_range(0, 3)];
                    ch = dim_edges[$urandom_range(0, 3)];
                end
                2: begin
                    cw = DIM_W'($urandom_range(1, 12));
                    ch = DIM_W'($urandom_range(1, 3));
                end
                default: begin
                    cw = DIM_W'($urandom_range(1, 6));
                    ch = DIM_W'($urandom_range(1, 6));
                end
            endcase
            write_grid_dims(cw, ch);
            wd = (cw == 0) ? 1 : ((cw > MAX_COLUMNS) ? MAX_COLUMNS : int'(cw));
            hd = (ch == 0) ? 1 : ((ch > MAX_ROWS) ? MAX_ROWS : int'(ch));
            // carving and backtracking take about two steps per cell
            steps = 2 * wd * hd + $urandom_range(0, 3);
            if (steps > 48) begin
                steps = $urandom_range(20, 48);
            end
            // most phases start afresh; the rest carry on the old maze under the new size
            if ($urandom_range(0, 6) != 0) begin
                queue_req(CMD_RESTART, 16'($urandom_range(0, 65535)));
            end
            for (int k = 0; k < steps; k++) begin
                if ($urandom_range(0, 39) == 0) begin
                    queue_req(CMD_RESTART, 16'($urandom_range(0, 65535)));
                end else begin
                    queue_req(CMD_STEP, 16'($urandom_range(0, 65535)));
                end
            end
            wait_idle();
        end

        // drain, then give the block time to show any stray result
        wait_idle();
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
